FILE: hw/rtl/tscc_pkg.sv
`default_nettype none

package tscc_pkg;

    // PID space and special identifiers
    localparam int PID_BITS   = 13;
    localparam int PID_COUNT  = 1 << PID_BITS;
    localparam logic [PID_BITS-1:0] NULL_PID = 13'h1FFF;

    // Last continuity counter: bit 4 set means no counter recorded yet
    localparam logic [4:0] CC_NONE = 5'h10;

    // Counter width; the result ports carry the same 32 bits
    localparam int COUNT_BITS = 32;
    typedef logic [COUNT_BITS-1:0] count_t;
    localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

    // Adaptation field control codes
    localparam logic [1:0] AFC_RESERVED = 2'd0;
    localparam logic [1:0] AFC_PAYLOAD  = 2'd1;
    localparam logic [1:0] AFC_ADAPT    = 2'd2;
    localparam logic [1:0] AFC_BOTH     = 2'd3;

    // Queue between front and back
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;

    // Classified packet header
    typedef struct packed {
        logic                err;
        logic [PID_BITS-1:0] pid;
        logic                is_null;
        logic                scrambled;
        logic [1:0]          afc;
        logic [3:0]          cc;
        logic                excuse;     // adaptation length nonzero and discontinuity set
    } item_t;

    // One PID record
    typedef struct packed {
        logic       known;
        logic [4:0] last_cc;
        logic       dup;
        count_t     packets;
        count_t     drops;
        count_t     scrambles;
    } pid_entry_t;

    // Queue status seen by the front
    typedef struct packed {
        logic full;
        logic clearing;
    } front_status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } back_state_t;

    // Saturating increment
    function automatic count_t sat_inc(input count_t v);
        sat_inc = (v == COUNT_MAX) ? v : v + count_t'(1);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tscc_front.sv
`default_nettype none

module tscc_front
    import tscc_pkg::*;
(
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                error_bit,
    input  wire logic [PID_BITS-1:0] pid,
    input  wire logic [1:0]          scrambling_control,
    input  wire logic [1:0]          adaptation_control,
    input  wire logic [3:0]          counter_value,
    input  wire logic [7:0]          byte_four,
    input  wire logic                discontinuity_bit,
    input  wire front_status_t       status,
    output logic                     push,
    output item_t                    item
);

    // Accept while the queue has room and the PID store is not being cleared
    assign in_ready = !status.full && !status.clearing;
    assign push     = in_valid && in_ready;

    // Header classification
    always_comb
    begin
        item.err       = error_bit;
        item.pid       = pid;
        item.is_null   = (pid == NULL_PID);
        item.scrambled = (scrambling_control != 2'd0);
        item.afc       = adaptation_control;
        item.cc        = counter_value;
        item.excuse    = (byte_four != 8'd0) && discontinuity_bit;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tscc_queue.sv
`default_nettype none

module tscc_queue
    import tscc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output logic       head_valid,
    output item_t      head_item
);

    item_t                     slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_BITS:0]   count_reg, count_next;

    assign full       = (count_reg == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QUEUE_PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QUEUE_PTR_BITS+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QUEUE_PTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tscc_back.sv
`default_nettype none

module tscc_back
    import tscc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_valid,
    input  wire item_t q_item,
    output logic       q_pop,
    output logic       clearing,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic       counted,
    output logic       drop_seen,
    output logic       scramble_seen,
    output logic [31:0] pid_packets,
    output logic [31:0] pid_drops,
    output logic [31:0] pid_scrambles,
    output logic [31:0] all_drops,
    output logic [31:0] all_scrambles
);

    back_state_t         state_reg, state_next;
    logic [PID_BITS-1:0] clr_addr_reg, clr_addr_next;

    pid_entry_t          pid_mem [PID_COUNT];
    pid_entry_t          rd_data_reg;
    item_t               cur_reg;

    count_t              drop_total_reg, drop_total_next;
    count_t              scr_total_reg, scr_total_next;

    logic                out_valid_reg, out_valid_next;
    logic                counted_reg, drop_seen_reg, scramble_seen_reg;
    count_t              pid_packets_reg, pid_drops_reg, pid_scrambles_reg;
    count_t              all_drops_reg, all_scrambles_reg;

    logic                rd_en, mem_we, out_load, fire;
    logic [PID_BITS-1:0] wr_addr;
    pid_entry_t          wr_data;
    pid_entry_t          base, upd;
    logic                valid_cc, unexcused, drop, scrambled, dup_new;

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == NULL_PID)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Output decode of the sequencer
    assign fire = !out_valid_reg || out_ready;

    always_comb
    begin
        clearing = 1'b0;
        q_pop    = 1'b0;
        rd_en    = 1'b0;
        mem_we   = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                clearing = 1'b1;
                mem_we   = 1'b1;
            end
            ST_IDLE:
            begin
                q_pop = q_valid;
                rd_en = q_valid;
            end
            ST_EXEC:
            begin
                out_load = fire;
                mem_we   = fire && !cur_reg.err;
            end
            default:
            begin
                clearing = 1'b0;
            end
        endcase
    end

    // Continuity check on the fetched record
    always_comb
    begin
        if (rd_data_reg.known)
        begin
            base = rd_data_reg;
        end
        else
        begin
            base = '{known: 1'b1, last_cc: CC_NONE, dup: 1'b0,
                     packets: '0, drops: '0, scrambles: '0};
        end

        valid_cc  = !base.last_cc[4];
        unexcused = (cur_reg.afc == AFC_PAYLOAD) || !cur_reg.excuse;
        drop      = 1'b0;
        dup_new   = 1'b0;

        case (cur_reg.afc)
            AFC_RESERVED:
            begin
                dup_new = 1'b0;
            end
            AFC_ADAPT:
            begin
                drop = valid_cc && (base.last_cc[3:0] != cur_reg.cc) && !cur_reg.excuse;
            end
            default:
            begin
                if (valid_cc && (base.last_cc[3:0] == cur_reg.cc))
                begin
                    // Repeated counter: one duplicate is allowed
                    if (unexcused)
                    begin
                        dup_new = 1'b1;
                        drop    = base.dup;
                    end
                end
                else
                begin
                    drop = valid_cc && unexcused
                        && ((base.last_cc[3:0] + 4'd1) != cur_reg.cc);
                end
            end
        endcase

        // Null PID: only the packet count moves
        if (cur_reg.is_null)
        begin
            drop      = 1'b0;
            scrambled = 1'b0;
        end
        else
        begin
            scrambled = cur_reg.scrambled;
        end

        upd           = base;
        upd.packets   = sat_inc(base.packets);
        upd.drops     = drop ? sat_inc(base.drops) : base.drops;
        upd.scrambles = scrambled ? sat_inc(base.scrambles) : base.scrambles;
        if (!cur_reg.is_null)
        begin
            upd.last_cc = {1'b0, cur_reg.cc};
            upd.dup     = dup_new;
        end

        drop_total_next = drop_total_reg;
        scr_total_next  = scr_total_reg;
        if (out_load && !cur_reg.err)
        begin
            if (drop)
            begin
                drop_total_next = sat_inc(drop_total_reg);
            end
            if (scrambled)
            begin
                scr_total_next = sat_inc(scr_total_reg);
            end
        end
    end

    // Write port: clearing sweep or record update
    always_comb
    begin
        if (clearing)
        begin
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_addr = cur_reg.pid;
            wr_data = upd;
        end
        clr_addr_next = clearing ? clr_addr_reg + PID_BITS'(1) : clr_addr_reg;
    end

    // PID store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pid_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= pid_mem[q_item.pid];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_item;
        end
    end

    // Control and totals
    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            drop_total_reg <= '0;
            scr_total_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            drop_total_reg <= drop_total_next;
            scr_total_reg  <= scr_total_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            all_drops_reg     <= drop_total_next;
            all_scrambles_reg <= scr_total_next;
            if (cur_reg.err)
            begin
                counted_reg       <= 1'b0;
                drop_seen_reg     <= 1'b0;
                scramble_seen_reg <= 1'b0;
                pid_packets_reg   <= '0;
                pid_drops_reg     <= '0;
                pid_scrambles_reg <= '0;
            end
            else
            begin
                counted_reg       <= 1'b1;
                drop_seen_reg     <= drop;
                scramble_seen_reg <= scrambled;
                pid_packets_reg   <= upd.packets;
                pid_drops_reg     <= upd.drops;
                pid_scrambles_reg <= upd.scrambles;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign counted       = counted_reg;
    assign drop_seen     = drop_seen_reg;
    assign scramble_seen = scramble_seen_reg;
    assign pid_packets   = pid_packets_reg;
    assign pid_drops     = pid_drops_reg;
    assign pid_scrambles = pid_scrambles_reg;
    assign all_drops     = all_drops_reg;
    assign all_scrambles = all_scrambles_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ts_continuity_drop_counter_core.sv
`default_nettype none

// Transport-stream continuity checker with per-PID drop and scramble counts.
// Input channel (in_valid/in_ready): the header fields of one packet per
// transfer. Output channel (out_valid/out_ready): one result per packet, in
// order, with the updated PID counts and the global totals.
// A front stage classifies the header and pushes it into a four-entry queue;
// the back sequencer reads the PID record, checks it, writes it back and
// loads the result register.
// Each packet takes a record read in ST_IDLE, then a check and write-back
// in ST_EXEC on the PID store, where it waits while the result register is
// stalled; the back pops the next packet only after the last one is done.
// An input packet passes through the queue, the record read and the result register.
// After reset the PID store is swept clear, one entry a cycle, over all
// 8192 entries; in_ready stays low throughout. Totals reset to zero.
// When the receiver stalls, the result register holds and the queue keeps
// taking packets until it is full, then in_ready drops.
module ts_continuity_drop_counter_core
    import tscc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                error_bit,
    input  wire logic [PID_BITS-1:0] pid,
    input  wire logic [1:0]          scrambling_control,
    input  wire logic [1:0]          adaptation_control,
    input  wire logic [3:0]          counter_value,
    input  wire logic [7:0]          byte_four,
    input  wire logic                discontinuity_bit,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     counted,
    output logic                     drop_seen,
    output logic                     scramble_seen,
    output logic [31:0]              pid_packets,
    output logic [31:0]              pid_drops,
    output logic [31:0]              pid_scrambles,
    output logic [31:0]              all_drops,
    output logic [31:0]              all_scrambles
);

    front_status_t status;
    logic          push, q_full, q_pop, q_valid, clearing;
    item_t         push_item, head_item;

    assign status.full     = q_full;
    assign status.clearing = clearing;

    // Header classification
    tscc_front u_front
    (
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .error_bit          (error_bit),
        .pid                (pid),
        .scrambling_control (scrambling_control),
        .adaptation_control (adaptation_control),
        .counter_value      (counter_value),
        .byte_four          (byte_four),
        .discontinuity_bit  (discontinuity_bit),
        .status             (status),
        .push               (push),
        .item               (push_item)
    );

    // Decoupling queue
    tscc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    // Record update and result
    tscc_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (head_item),
        .q_pop         (q_pop),
        .clearing      (clearing),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .counted       (counted),
        .drop_seen     (drop_seen),
        .scramble_seen (scramble_seen),
        .pid_packets   (pid_packets),
        .pid_drops     (pid_drops),
        .pid_scrambles (pid_scrambles),
        .all_drops     (all_drops),
        .all_scrambles (all_scrambles)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb_ts_continuity_drop_counter_core.sv
`timescale 1ns / 1ps

module tb_ts_continuity_drop_counter_core;
    import tscc_pkg::*;

    localparam int N_STREAMS   = 8;
    localparam int HOLD_CYCLES = 200;
    localparam int TAIL_CYCLES = 20;

    // One packet header as offered on the input channel
    typedef struct {
        logic                err;
        logic [PID_BITS-1:0] pid;
        logic [1:0]          scr;
        logic [1:0]          afc;
        logic [3:0]          cc;
        logic [7:0]          b4;
        logic                disc;
    } hdr_t;

    // One result as seen on the output channel
    typedef struct {
        logic   counted;
        logic   drop;
        logic   scrambled;
        count_t packets;
        count_t drops;
        count_t scrambles;
        count_t total_drops;
        count_t total_scrambles;
    } stats_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                error_bit = 1'b0;
    logic [PID_BITS-1:0] pid = '0;
    logic [1:0]          scrambling_control = '0;
    logic [1:0]          adaptation_control = '0;
    logic [3:0]          counter_value = '0;
    logic [7:0]          byte_four = '0;
    logic                discontinuity_bit = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                counted;
    logic                drop_seen;
    logic                scramble_seen;
    logic [31:0]         pid_packets;
    logic [31:0]         pid_drops;
    logic [31:0]         pid_scrambles;
    logic [31:0]         all_drops;
    logic [31:0]         all_scrambles;

    ts_continuity_drop_counter_core dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .error_bit          (error_bit),
        .pid                (pid),
        .scrambling_control (scrambling_control),
        .adaptation_control (adaptation_control),
        .counter_value      (counter_value),
        .byte_four          (byte_four),
        .discontinuity_bit  (discontinuity_bit),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .counted            (counted),
        .drop_seen          (drop_seen),
        .scramble_seen      (scramble_seen),
        .pid_packets        (pid_packets),
        .pid_drops          (pid_drops),
        .pid_scrambles      (pid_scrambles),
        .all_drops          (all_drops),
        .all_scrambles      (all_scrambles)
    );

    // Headers waiting to be sent, and results still due
    hdr_t   header_q[$];
    stats_t stats_due_q[$];
    hdr_t   cur_hdr;

    // Traffic shaping
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit hold_req = 1'b0;
    int hold_cnt = 0;

    int mismatches = 0;
    int n_hdrs_in = 0;
    int n_errored = 0;
    int n_stats_out = 0;
    int n_drop_flags = 0;
    int n_scr_flags = 0;

    // Shadow of the PID store and the global totals
    bit         shadow_known [PID_COUNT];
    logic [4:0] shadow_cc    [PID_COUNT];
    bit         shadow_dup   [PID_COUNT];
    count_t     shadow_pkts  [PID_COUNT];
    count_t     shadow_drops [PID_COUNT];
    count_t     shadow_scrs  [PID_COUNT];
    count_t     shadow_drop_total = '0;
    count_t     shadow_scr_total = '0;

    // Stream generator state
    logic [PID_BITS-1:0] stream_pid [N_STREAMS];
    logic [3:0]          stream_cc  [N_STREAMS];

    function automatic count_t bump(input count_t v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Continuity check and counter update for one accepted header
    function automatic stats_t tally_packet(input hdr_t h);
        stats_t r;
        logic [4:0] prev;
        bit have_cc;
        bit unexcused;
        r = '{default: '0};
        if (h.err) begin
            r.total_drops = shadow_drop_total;
            r.total_scrambles = shadow_scr_total;
            return r;
        end
        if (!shadow_known[h.pid]) begin
            shadow_known[h.pid] = 1'b1;
            shadow_cc[h.pid] = CC_NONE;
            shadow_dup[h.pid] = 1'b0;
            shadow_pkts[h.pid] = '0;
            shadow_drops[h.pid] = '0;
            shadow_scrs[h.pid] = '0;
        end
        shadow_pkts[h.pid] = bump(shadow_pkts[h.pid]);
        if (h.pid != NULL_PID) begin
            prev = shadow_cc[h.pid];
            have_cc = !prev[4];
            unexcused = (h.afc == AFC_PAYLOAD) || (h.b4 == 8'd0) || !h.disc;
            r.scrambled = (h.scr != 2'd0);
            if (h.afc == AFC_RESERVED) begin
                shadow_dup[h.pid] = 1'b0;
            end else if (h.afc == AFC_ADAPT) begin
                if (have_cc && prev[3:0] != h.cc && (h.b4 == 8'd0 || !h.disc))
                    r.drop = 1'b1;
                shadow_dup[h.pid] = 1'b0;
            end else if (have_cc && prev[3:0] == h.cc) begin
                // repeated counter: one duplicate allowed unless excused
                if (unexcused) begin
                    if (!shadow_dup[h.pid])
                        shadow_dup[h.pid] = 1'b1;
                    else
                        r.drop = 1'b1;
                end else begin
                    shadow_dup[h.pid] = 1'b0;
                end
            end else begin
                if (have_cc && 4'(prev[3:0] + 4'd1) != h.cc && unexcused)
                    r.drop = 1'b1;
                shadow_dup[h.pid] = 1'b0;
            end
            shadow_cc[h.pid] = {1'b0, h.cc};
            if (r.scrambled) begin
                shadow_scrs[h.pid] = bump(shadow_scrs[h.pid]);
                shadow_scr_total = bump(shadow_scr_total);
            end
            if (r.drop) begin
                shadow_drops[h.pid] = bump(shadow_drops[h.pid]);
                shadow_drop_total = bump(shadow_drop_total);
            end
        end
        r.counted = 1'b1;
        r.packets = shadow_pkts[h.pid];
        r.drops = shadow_drops[h.pid];
        r.scrambles = shadow_scrs[h.pid];
        r.total_drops = shadow_drop_total;
        r.total_scrambles = shadow_scr_total;
        return r;
    endfunction

    task automatic push_hdr(input logic e, input logic [PID_BITS-1:0] p, input logic [1:0] s,
                            input logic [1:0] a, input logic [3:0] c, input logic [7:0] b,
                            input logic d);
        hdr_t h;
        h.err = e;
        h.pid = p;
        h.scr = s;
        h.afc = a;
        h.cc = c;
        h.b4 = b;
        h.disc = d;
        header_q.push_back(h);
    endtask

    // Mostly well-formed streams on a few PIDs, with duplicates, gaps,
    // discontinuities and some fully random noise
    task automatic gen_random(input int n);
        hdr_t h;
        int s;
        int roll;
        int k;
        for (int i = 0; i < N_STREAMS; i++) begin
            stream_pid[i] = 13'($urandom_range(8190));
            stream_cc[i] = 4'($urandom);
        end
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            h.err = ($urandom_range(99) < 3);
            h.scr = ($urandom_range(99) < 70) ? 2'd0 : 2'($urandom);
            h.b4 = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom);
            h.disc = ($urandom_range(7) == 0);
            if (roll < 15) begin
                h.pid = ($urandom_range(9) == 0) ? NULL_PID : 13'($urandom);
                h.afc = 2'($urandom);
                h.cc = 4'($urandom);
                h.b4 = 8'($urandom);
                h.disc = 1'($urandom);
            end else begin
                s = $urandom_range(N_STREAMS - 1);
                h.pid = stream_pid[s];
                k = $urandom_range(99);
                if (k < 65) begin
                    stream_cc[s] = stream_cc[s] + 4'd1;
                    h.afc = $urandom_range(1) ? AFC_PAYLOAD : AFC_BOTH;
                end else if (k < 75) begin
                    h.afc = $urandom_range(1) ? AFC_PAYLOAD : AFC_BOTH;
                end else if (k < 85) begin
                    h.afc = AFC_ADAPT;
                    if ($urandom_range(3) == 0)
                        stream_cc[s] = 4'($urandom);
                end else if (k < 92) begin
                    h.afc = AFC_BOTH;
                    h.b4 = 8'($urandom_range(255, 1));
                    h.disc = 1'b1;
                    stream_cc[s] = 4'($urandom);
                end else if (k < 96) begin
                    h.afc = $urandom_range(1) ? AFC_PAYLOAD : AFC_BOTH;
                    stream_cc[s] = 4'($urandom);
                end else begin
                    h.afc = AFC_RESERVED;
                    stream_cc[s] = 4'($urandom);
                end
                h.cc = stream_cc[s];
            end
            header_q.push_back(h);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d (0x%08h) got %0d (0x%08h)",
                     $time, name, want, want, got, got);
            mismatches++;
        end
    endtask

    // Sender idles, then waits for every transfer and every result
    task automatic drain;
        while (header_q.size() != 0 || in_valid)
            @(negedge clk);
        while (stats_due_q.size() != 0)
            @(negedge clk);
    endtask

    // Clock
    initial begin
        forever #5 clk = ~clk;
    end

    // Input driver: predicts on each transfer, then offers the next header
    always @(posedge clk) begin : drv
        hdr_t nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                stats_due_q.push_back(tally_packet(cur_hdr));
                n_hdrs_in++;
                if (cur_hdr.err)
                    n_errored++;
            end
            if (!in_valid || in_ready) begin
                if (header_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = header_q.pop_front();
                    cur_hdr <= nxt;
                    error_bit <= nxt.err;
                    pid <= nxt.pid;
                    scrambling_control <= nxt.scr;
                    adaptation_control <= nxt.afc;
                    counter_value <= nxt.cc;
                    byte_four <= nxt.b4;
                    discontinuity_bit <= nxt.disc;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure, with one long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
            hold_cnt <= hold_cnt + 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Output monitor
    always @(posedge clk) begin : mon
        stats_t want;
        if (rst_n && out_valid && out_ready) begin
            n_stats_out++;
            if (drop_seen === 1'b1)
                n_drop_flags++;
            if (scramble_seen === 1'b1)
                n_scr_flags++;
            if (stats_due_q.size() == 0) begin
                $display("%0t: result with none expected, pid_packets %0d all_drops %0d",
                         $time, pid_packets, all_drops);
                mismatches++;
            end else begin
                want = stats_due_q.pop_front();
                check_field("counted", 32'(want.counted), 32'(counted));
                check_field("drop_seen", 32'(want.drop), 32'(drop_seen));
                check_field("scramble_seen", 32'(want.scrambled), 32'(scramble_seen));
                check_field("pid_packets", want.packets, pid_packets);
                check_field("pid_drops", want.drops, pid_drops);
                check_field("pid_scrambles", want.scrambles, pid_scrambles);
                check_field("all_drops", want.total_drops, all_drops);
                check_field("all_scrambles", want.total_scrambles, all_scrambles);
            end
        end
    end

    // Run limit
    initial begin
        #3_000_000;
        $display("ts_continuity_drop_counter_core: mismatch");
        $finish;
    end

    // Sequence of phases
    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed headers, no idling
        push_hdr(1'b1, NULL_PID, 2'd3, AFC_BOTH, 4'd15, 8'd255, 1'b1); // error, nothing known
        push_hdr(1'b0, 13'd0, 2'd0, AFC_PAYLOAD, 4'd0, 8'd0, 1'b0);     // first packet
        push_hdr(1'b0, 13'd0, 2'd0, AFC_PAYLOAD, 4'd1, 8'd0, 1'b0);
        push_hdr(1'b0, 13'd0, 2'd0, AFC_PAYLOAD, 4'd1, 8'd0, 1'b0);     // allowed duplicate
        push_hdr(1'b0, 13'd0, 2'd0, AFC_PAYLOAD, 4'd1, 8'd0, 1'b0);     // second duplicate
        push_hdr(1'b0, 13'd0, 2'd0, AFC_PAYLOAD, 4'd2, 8'd0, 1'b0);
        push_hdr(1'b0, 13'd0, 2'd0, AFC_ADAPT, 4'd2, 8'd0, 1'b0);       // adaptation, same cc
        push_hdr(1'b0, 13'd0, 2'd0, AFC_ADAPT, 4'd5, 8'd0, 1'b1);       // adaptation, cc moved
        push_hdr(1'b0, 13'd0, 2'd0, AFC_ADAPT, 4'd7, 8'd1, 1'b1);       // excused change
        push_hdr(1'b0, 13'd0, 2'd0, AFC_BOTH, 4'd7, 8'd3, 1'b1);        // excused repeat
        push_hdr(1'b0, 13'd0, 2'd0, AFC_BOTH, 4'd12, 8'd255, 1'b1);     // excused gap
        push_hdr(1'b0, 13'd0, 2'd0, AFC_PAYLOAD, 4'd0, 8'd255, 1'b1);   // payload only gap
        push_hdr(1'b0, 13'd0, 2'd2, AFC_RESERVED, 4'd9, 8'd0, 1'b0);    // reserved, scrambled
        push_hdr(1'b0, 13'd0, 2'd1, AFC_PAYLOAD, 4'd10, 8'd0, 1'b0);
        push_hdr(1'b0, 13'd0, 2'd0, AFC_PAYLOAD, 4'd15, 8'd0, 1'b0);
        push_hdr(1'b0, 13'd0, 2'd0, AFC_PAYLOAD, 4'd0, 8'd0, 1'b0);     // wrap 15 to 0
        push_hdr(1'b0, NULL_PID, 2'd3, AFC_PAYLOAD, 4'd3, 8'd0, 1'b0);  // null PID
        push_hdr(1'b0, NULL_PID, 2'd1, AFC_ADAPT, 4'd9, 8'd7, 1'b1);
        push_hdr(1'b1, 13'd0, 2'd3, AFC_PAYLOAD, 4'd1, 8'd0, 1'b0);     // error on known PID
        push_hdr(1'b0, 13'd8190, 2'd1, AFC_ADAPT, 4'd15, 8'd0, 1'b0);
        push_hdr(1'b0, 13'd8190, 2'd0, AFC_BOTH, 4'd15, 8'd0, 1'b1);    // repeat, no length
        push_hdr(1'b0, 13'd8190, 2'd3, AFC_BOTH, 4'd0, 8'd0, 1'b0);
        push_hdr(1'b0, 13'h0AAA, 2'd0, AFC_RESERVED, 4'd5, 8'h55, 1'b0);
        push_hdr(1'b0, 13'h1555, 2'd2, AFC_BOTH, 4'd5, 8'h80, 1'b0);
        drain();

        // Long receiver hold-off while the sender keeps offering
        gen_random(250);
        hold_req = 1'b1;
        drain();

        // Sender idles most cycles
        tx_idle_pct = 72;
        gen_random(200);
        drain();

        // Receiver stalls most cycles
        tx_idle_pct = 0;
        rx_stall_pct = 72;
        gen_random(200);
        drain();

        // Both sides idle a quarter of the time
        tx_idle_pct = 26;
        rx_stall_pct = 26;
        gen_random(200);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (stats_due_q.size() != 0) begin
            $display("%0t: %0d results still outstanding", $time, stats_due_q.size());
            mismatches++;
        end

        $display("Sent %0d headers (%0d with error bit), checked %0d results", n_hdrs_in,
                 n_errored, n_stats_out);
        $display("Drops flagged %0d, scrambles flagged %0d, field mismatches %0d",
                 n_drop_flags, n_scr_flags, mismatches);
        if (mismatches == 0)
            $display("ts_continuity_drop_counter_core: match");
        else
            $display("ts_continuity_drop_counter_core: mismatch");
        $finish;
    end

endmodule
